FILE: design/drpk_pkg.sv
// Package for the DER RSA public key parser: parse phases, codes, result beat type.
`default_nettype none
package drpk_pkg;

	localparam int unsigned MAX_INT_BYTES = 512;

	localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
	localparam logic [7:0] TAG_INTEGER    = 8'h02;
	localparam logic [7:0] TAG_BIT_STRING = 8'h03;
	localparam logic [7:0] LEN_LONG_FORM  = 8'h80;
	localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;
	localparam logic [7:0] ZERO_BYTE      = 8'h00;
	localparam logic [2:0] MAX_LEN_BYTES  = 3'd4;
	localparam logic [9:0] COUNT_SAT      = 10'h3FF;

	typedef enum logic [4:0] {
		PH_OUTER_TAG  = 5'd0,
		PH_OUTER_LEN  = 5'd1,
		PH_OUTER_LENX = 5'd2,
		PH_PEEK       = 5'd3,
		PH_ALG_LEN    = 5'd4,
		PH_ALG_LENX   = 5'd5,
		PH_ALG_SKIP   = 5'd6,
		PH_BIT_TAG    = 5'd7,
		PH_BIT_LEN    = 5'd8,
		PH_BIT_LENX   = 5'd9,
		PH_UNUSED     = 5'd10,
		PH_INNER_TAG  = 5'd11,
		PH_INNER_LEN  = 5'd12,
		PH_INNER_LENX = 5'd13,
		PH_MOD_TAG    = 5'd14,
		PH_MOD_LEN    = 5'd15,
		PH_MOD_LENX   = 5'd16,
		PH_MOD_DATA   = 5'd17,
		PH_EXP_TAG    = 5'd18,
		PH_EXP_LEN    = 5'd19,
		PH_EXP_LENX   = 5'd20,
		PH_EXP_DATA   = 5'd21,
		PH_TRAIL      = 5'd22,
		PH_ERROR      = 5'd23
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TAG   = 3'd1,
		ST_FORM  = 3'd2,
		ST_TRUNC = 3'd3,
		ST_BIG   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_MOD  = 2'd0,
		KIND_EXP  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		status_t    status;
		logic [9:0] ksize;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

FILE: design/der_rsa_public_key_parser_unit.sv
// Top level: streaming DER RSA public key parser with output result queue.
//
// Input channel: one key byte per beat (der_byte), end_of_key set on the
// final byte. Output channel: result beats with item_kind, data_byte,
// status, key_size_bytes and last. Modulus and exponent bytes are streamed
// most significant first with one leading zero stripped; the final input
// byte adds a done beat (last = 1) with status and the modulus size if OK.
//
// An accepted byte is held in the input register, is parsed and written to
// a four-entry result queue, from which its results are offered. One byte
// is taken per cycle as long as the queue holds at most two results, so the
// rate is one byte per cycle while the receiver takes a beat per cycle; a
// final byte that gives both a data and a done beat puts two results into
// the queue.
// When the receiver stalls the queue fills and in_ready drops; nothing is
// lost. Reset clears the parse state to expect a new key and empties the
// queue. After each done beat the parse state returns to its reset values.
`default_nettype none
module der_rsa_public_key_parser_unit
	import drpk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] der_byte,
	input  wire logic       end_of_key,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      item_kind,
	output logic [7:0]      data_byte,
	output logic [2:0]      status,
	output logic [9:0]      key_size_bytes,
	output logic            last
);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// parse state
	phase_t      phase_q;
	logic [31:0] len_acc_q;
	logic [2:0]  len_left_q;
	logic [31:0] remain_q;
	logic        first_q;
	logic [9:0]  mod_cnt_q;
	logic        seen_nz_q;
	status_t     err_q;

	// result queue
	result_t         queue_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;

	logic adv;
	logic pop;

	phase_t      ph_n;
	logic [31:0] la_n;
	logic [2:0]  ll_n;
	logic [31:0] rm_n;
	logic        fi_n;
	logic [9:0]  mc_n;
	logic        sn_n;
	status_t     er_n;
	logic        r0_v;
	result_t     r0;
	logic        r1_v;
	result_t     r1;

	assign adv      = v_s1 && (cnt_q <= QCW'(QDEPTH - 2));
	assign in_ready = !v_s1 || adv;
	assign pop      = out_valid && out_ready;

	always_comb begin
		logic    lc;
		phase_t  base;
		logic [6:0]  nlen;
		logic [31:0] eff;
		logic        is_mod;
		logic        emit;
		logic        sn_t;
		status_t     st;
		ph_n   = phase_q;
		la_n   = len_acc_q;
		ll_n   = len_left_q;
		rm_n   = remain_q;
		fi_n   = first_q;
		mc_n   = mod_cnt_q;
		sn_n   = seen_nz_q;
		er_n   = err_q;
		lc     = 1'b0;
		base   = phase_q;
		nlen   = byte_s1[6:0] & LEN_COUNT_MASK;
		eff    = remain_q - {31'd0, byte_s1 == ZERO_BYTE};
		is_mod = (phase_q == PH_MOD_DATA);
		emit   = 1'b0;
		sn_t   = seen_nz_q;
		st     = ST_OK;
		r0_v   = 1'b0;
		r0     = '{kind: KIND_MOD, data: byte_s1, status: ST_OK, ksize: 10'd0, last: 1'b0};
		r1_v   = 1'b0;
		r1     = '{kind: KIND_DONE, data: 8'd0, status: ST_OK, ksize: 10'd0, last: 1'b1};

		case (phase_q)
			PH_OUTER_TAG, PH_INNER_TAG: begin
				if (byte_s1 == TAG_SEQUENCE)
					ph_n = (phase_q == PH_OUTER_TAG) ? PH_OUTER_LEN : PH_INNER_LEN;
				else begin
					er_n = ST_TAG;
					ph_n = PH_ERROR;
				end
			end
			PH_PEEK: begin
				if (byte_s1 == TAG_SEQUENCE) ph_n = PH_ALG_LEN;
				else if (byte_s1 == TAG_INTEGER) ph_n = PH_MOD_LEN;
				else begin
					er_n = ST_TAG;
					ph_n = PH_ERROR;
				end
			end
			PH_BIT_TAG: begin
				if (byte_s1 == TAG_BIT_STRING) ph_n = PH_BIT_LEN;
				else begin
					er_n = ST_TAG;
					ph_n = PH_ERROR;
				end
			end
			PH_MOD_TAG, PH_EXP_TAG: begin
				if (byte_s1 == TAG_INTEGER)
					ph_n = (phase_q == PH_MOD_TAG) ? PH_MOD_LEN : PH_EXP_LEN;
				else begin
					er_n = ST_TAG;
					ph_n = PH_ERROR;
				end
			end
			PH_OUTER_LEN, PH_ALG_LEN, PH_BIT_LEN, PH_INNER_LEN, PH_MOD_LEN,
			PH_EXP_LEN: begin
				if ((byte_s1 & LEN_LONG_FORM) == ZERO_BYTE) begin
					la_n = {24'd0, byte_s1};
					lc   = 1'b1;
				end else begin
					la_n = 32'd0;
					if (nlen > {4'd0, MAX_LEN_BYTES}) begin
						er_n = ST_FORM;
						ph_n = PH_ERROR;
					end else if (nlen == 7'd0) begin
						lc = 1'b1;
					end else begin
						ll_n = nlen[2:0];
						ph_n = phase_t'(phase_q + 5'd1);
					end
				end
			end
			PH_OUTER_LENX, PH_ALG_LENX, PH_BIT_LENX, PH_INNER_LENX, PH_MOD_LENX,
			PH_EXP_LENX: begin
				la_n = {len_acc_q[23:0], byte_s1};
				ll_n = len_left_q - 3'd1;
				base = phase_t'(phase_q - 5'd1);
				lc   = (ll_n == 3'd0);
			end
			PH_ALG_SKIP: begin
				rm_n = remain_q - 32'd1;
				if (rm_n == 32'd0) ph_n = PH_BIT_TAG;
			end
			PH_UNUSED: ph_n = PH_INNER_TAG;
			PH_MOD_DATA, PH_EXP_DATA: begin
				emit = 1'b1;
				if (first_q && eff > MAX_INT_BYTES) begin
					fi_n = 1'b0;
					er_n = ST_BIG;
					ph_n = PH_ERROR;
					emit = 1'b0;
				end else begin
					if (first_q) begin
						fi_n = 1'b0;
						if (byte_s1 == ZERO_BYTE) emit = 1'b0;
					end
					if (emit && is_mod) begin
						sn_t = seen_nz_q || (byte_s1 != ZERO_BYTE);
						sn_n = sn_t;
						if (sn_t && mod_cnt_q != COUNT_SAT) mc_n = mod_cnt_q + 10'd1;
					end
					r0_v    = emit;
					r0.kind = is_mod ? KIND_MOD : KIND_EXP;
					rm_n    = remain_q - 32'd1;
					if (rm_n == 32'd0) ph_n = is_mod ? PH_EXP_TAG : PH_TRAIL;
				end
			end
			default: ;
		endcase

		if (lc) begin
			case (base)
				PH_OUTER_LEN: ph_n = PH_PEEK;
				PH_ALG_LEN: begin
					if (la_n == 32'd0) ph_n = PH_BIT_TAG;
					else begin
						rm_n = la_n;
						ph_n = PH_ALG_SKIP;
					end
				end
				PH_BIT_LEN:   ph_n = PH_UNUSED;
				PH_INNER_LEN: ph_n = PH_MOD_TAG;
				PH_MOD_LEN: begin
					if (la_n == 32'd0) ph_n = PH_EXP_TAG;
					else begin
						rm_n = la_n;
						fi_n = 1'b1;
						ph_n = PH_MOD_DATA;
					end
				end
				default: begin
					if (la_n == 32'd0) ph_n = PH_TRAIL;
					else begin
						rm_n = la_n;
						fi_n = 1'b1;
						ph_n = PH_EXP_DATA;
					end
				end
			endcase
		end

		if (fin_s1) begin
			if (er_n != ST_OK) st = er_n;
			else if (ph_n == PH_TRAIL) st = ST_OK;
			else st = ST_TRUNC;
			r1_v     = 1'b1;
			r1.status = st;
			r1.ksize  = (st == ST_OK) ? mc_n : 10'd0;
			ph_n = PH_OUTER_TAG;
			la_n = 32'd0;
			ll_n = 3'd0;
			rm_n = 32'd0;
			fi_n = 1'b1;
			mc_n = 10'd0;
			sn_n = 1'b0;
			er_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= der_byte;
			fin_s1  <= end_of_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OUTER_TAG;
			len_acc_q  <= 32'd0;
			len_left_q <= 3'd0;
			remain_q   <= 32'd0;
			first_q    <= 1'b1;
			mod_cnt_q  <= 10'd0;
			seen_nz_q  <= 1'b0;
			err_q      <= ST_OK;
		end else if (adv) begin
			phase_q    <= ph_n;
			len_acc_q  <= la_n;
			len_left_q <= ll_n;
			remain_q   <= rm_n;
			first_q    <= fi_n;
			mod_cnt_q  <= mc_n;
			seen_nz_q  <= sn_n;
			err_q      <= er_n;
		end
	end

	logic [1:0] push_n;
	assign push_n = adv ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			cnt_q <= cnt_q + QCW'(push_n) - QCW'(pop);
		end
	end

	// the data beat goes ahead of the done beat
	always_ff @(posedge clk) begin
		if (adv) begin
			if (r0_v) begin
				queue_q[wr_ptr_q] <= r0;
				if (r1_v) queue_q[wr_ptr_q + QAW'(1)] <= r1;
			end else if (r1_v) begin
				queue_q[wr_ptr_q] <= r1;
			end
		end
	end

	assign out_valid      = (cnt_q != '0);
	assign item_kind      = queue_q[rd_ptr_q].kind;
	assign data_byte      = queue_q[rd_ptr_q].data;
	assign status         = queue_q[rd_ptr_q].status;
	assign key_size_bytes = queue_q[rd_ptr_q].ksize;
	assign last           = queue_q[rd_ptr_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("result queue overflow");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (item_kind == KIND_DONE))
		else $error("last set on a data beat");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind != KIND_DONE)
		|-> (status == ST_OK && key_size_bytes == 10'd0))
		else $error("data beat carries status or size");

	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin_s1) |=> (phase_q == PH_OUTER_TAG && err_q == ST_OK && mod_cnt_q == 10'd0))
		else $error("parse state not cleared after final byte");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (cnt_q <= QCW'(QDEPTH - 2)))
		else $error("byte parsed without queue room");

endmodule
`default_nettype wire

FILE: test/der_rsa_public_key_parser_unit_test.sv
// Testbench for the DER RSA public key parser: predicted beats checked under random handshakes.
module der_rsa_public_key_parser_unit_test
	import drpk_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	class parse_scoreboard;
		result_t expected_beats[$];
		phase_t phase;
		logic [31:0] len_acc;
		logic [2:0] len_left;
		logic [31:0] remaining;
		bit first_byte;
		logic [9:0] mod_count;
		bit nonzero_seen;
		status_t err;
		int mismatches;
		int checked;
		int done_count[5];

		function new();
			clear_state();
		endfunction

		function void clear_state();
			phase = PH_OUTER_TAG;
			len_acc = '0;
			len_left = '0;
			remaining = '0;
			first_byte = 1'b1;
			mod_count = '0;
			nonzero_seen = 1'b0;
			err = ST_OK;
		endfunction

		function void raise(status_t code);
			err = code;
			phase = PH_ERROR;
		endfunction

		function void push(kind_t kind, logic [7:0] data, status_t st, logic [9:0] ksize);
			result_t r;
			r.kind = kind;
			r.data = data;
			r.status = st;
			r.ksize = ksize;
			r.last = (kind == KIND_DONE);
			expected_beats.push_back(r);
		endfunction

		function void begin_integer(phase_t data_ph, phase_t next_ph);
			if (len_acc == 0) begin
				phase = next_ph;
			end else begin
				remaining = len_acc;
				first_byte = 1'b1;
				phase = data_ph;
			end
		endfunction

		function void length_done(phase_t base);
			case (base)
			PH_OUTER_LEN: phase = PH_PEEK;
			PH_ALG_LEN: begin
				if (len_acc == 0) begin
					phase = PH_BIT_TAG;
				end else begin
					remaining = len_acc;
					phase = PH_ALG_SKIP;
				end
			end
			PH_BIT_LEN: phase = PH_UNUSED;
			PH_INNER_LEN: phase = PH_MOD_TAG;
			PH_MOD_LEN: begin_integer(PH_MOD_DATA, PH_EXP_TAG);
			default: begin_integer(PH_EXP_DATA, PH_TRAIL);
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			logic [6:0] n;
			logic [31:0] eff;
			bit is_mod;
			bit keep;
			status_t st;
			case (phase)
			PH_OUTER_TAG, PH_INNER_TAG: begin
				if (b == TAG_SEQUENCE) phase = phase_t'(phase + 1);
				else raise(ST_TAG);
			end
			PH_PEEK: begin
				if (b == TAG_SEQUENCE) phase = PH_ALG_LEN;
				else if (b == TAG_INTEGER) phase = PH_MOD_LEN;
				else raise(ST_TAG);
			end
			PH_BIT_TAG: begin
				if (b == TAG_BIT_STRING) phase = PH_BIT_LEN;
				else raise(ST_TAG);
			end
			PH_MOD_TAG, PH_EXP_TAG: begin
				if (b == TAG_INTEGER) phase = phase_t'(phase + 1);
				else raise(ST_TAG);
			end
			PH_OUTER_LEN, PH_ALG_LEN, PH_BIT_LEN, PH_INNER_LEN, PH_MOD_LEN, PH_EXP_LEN: begin
				if (b < LEN_LONG_FORM) begin
					len_acc = {24'd0, b};
					length_done(phase);
				end else begin
					n = b[6:0] & LEN_COUNT_MASK;
					len_acc = '0;
					if (n > MAX_LEN_BYTES) begin
						raise(ST_FORM);
					end else if (n == 0) begin
						length_done(phase);
					end else begin
						len_left = n[2:0];
						phase = phase_t'(phase + 1);
					end
				end
			end
			PH_OUTER_LENX, PH_ALG_LENX, PH_BIT_LENX, PH_INNER_LENX, PH_MOD_LENX,
			PH_EXP_LENX: begin
				len_acc = {len_acc[23:0], b};
				len_left = len_left - 3'd1;
				if (len_left == 0) length_done(phase_t'(phase - 1));
			end
			PH_ALG_SKIP: begin
				remaining--;
				if (remaining == 0) phase = PH_BIT_TAG;
			end
			PH_UNUSED: phase = PH_INNER_TAG;
			PH_MOD_DATA, PH_EXP_DATA: begin
				is_mod = (phase == PH_MOD_DATA);
				keep = 1'b1;
				if (first_byte) begin
					eff = remaining - ((b == ZERO_BYTE) ? 32'd1 : 32'd0);
					first_byte = 1'b0;
					if (eff > MAX_INT_BYTES) raise(ST_BIG);
					else if (b == ZERO_BYTE) keep = 1'b0;
				end
				if (phase != PH_ERROR) begin
					if (keep) begin
						if (is_mod) begin
							if (b != ZERO_BYTE) nonzero_seen = 1'b1;
							if (nonzero_seen && mod_count < COUNT_SAT) mod_count++;
							push(KIND_MOD, b, ST_OK, '0);
						end else begin
							push(KIND_EXP, b, ST_OK, '0);
						end
					end
					remaining--;
					if (remaining == 0) begin
						if (is_mod) phase = PH_EXP_TAG;
						else phase = PH_TRAIL;
					end
				end
			end
			default: ;
			endcase
			if (fin) begin
				if (err != ST_OK) st = err;
				else if (phase == PH_TRAIL) st = ST_OK;
				else st = ST_TRUNC;
				push(KIND_DONE, ZERO_BYTE, st, (st == ST_OK) ? mod_count : 10'd0);
				clear_state();
			end
		endfunction

		function string show(result_t r);
			return $sformatf("kind %0d byte %02h status %0d size %0d last %0b",
				r.kind, r.data, r.status, r.ksize, r.last);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%0t MISMATCH %s", $time, msg);
		endfunction

		function void check_beat(result_t got);
			result_t want;
			checked++;
			if (expected_beats.size() == 0) begin
				flag($sformatf("unexpected beat: %s", show(got)));
				return;
			end
			want = expected_beats.pop_front();
			if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status
				|| got.ksize !== want.ksize || got.last !== want.last)
				flag($sformatf("beat %0d: expected %s, got %s", checked, show(want), show(got)));
			else if (got.kind == KIND_DONE)
				done_count[got.status]++;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] der_byte = 8'h00;
	logic end_of_key = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [1:0] item_kind;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic [9:0] key_size_bytes;
	logic last;

	parse_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int keys_sent = 0;
	int beats_sent = 0;
	int useful_beats = 0;

	der_rsa_public_key_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.der_byte(der_byte),
		.end_of_key(end_of_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.data_byte(data_byte),
		.status(status),
		.key_size_bytes(key_size_bytes),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat({item_kind, data_byte, status, key_size_bytes, last});
	end

	function automatic void put_len(ref logic [7:0] q[$], input int unsigned len);
		int unsigned need;
		int unsigned width;
		need = (len < 32'h80) ? 0 : (len < 32'h100) ? 1 : (len < 32'h1_0000) ? 2 :
			(len < 32'h100_0000) ? 3 : 4;
		if (len == 0 && $urandom_range(3) == 0) begin
			q.push_back(LEN_LONG_FORM);
		end else if (need == 0 && $urandom_range(3) != 0) begin
			q.push_back(len[7:0]);
		end else begin
			width = $urandom_range(4, (need == 0) ? 1 : need);
			q.push_back(LEN_LONG_FORM | width[7:0]);
			for (int i = width - 1; i >= 0; i--)
				q.push_back(len[8 * i +: 8]);
		end
	endfunction

	function automatic void put_integer(ref logic [7:0] q[$], input int unsigned nbytes);
		int unsigned zeros;
		zeros = $urandom_range(7);
		zeros = (zeros < 3) ? 0 : (zeros < 7) ? 1 : $urandom_range(3, 2);
		q.push_back(TAG_INTEGER);
		put_len(q, nbytes);
		for (int unsigned i = 0; i < nbytes; i++)
			q.push_back((i < zeros) ? ZERO_BYTE : 8'($urandom_range(255)));
	endfunction

	function automatic void wrap(ref logic [7:0] q[$], input logic [7:0] tag,
		input logic [7:0] body[$]);
		q.push_back(tag);
		put_len(q, body.size());
		foreach (body[i]) q.push_back(body[i]);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic fin);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		der_byte <= b;
		end_of_key <= fin;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_byte(b, fin);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_key(input logic [7:0] k[$]);
		foreach (k[i]) send_beat(k[i], i == k.size() - 1);
		keys_sent++;
	endtask

	initial begin
		logic [7:0] key[$];
		logic [7:0] ints[$];
		logic [7:0] alg[$];
		logic [7:0] bits[$];
		logic [7:0] outer[$];
		int unsigned pick;
		int unsigned big_len;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wrong first tag, oversized length form, empty integers with trailing byte
		key = {8'h31};
		send_key(key);
		key = {TAG_SEQUENCE, 8'h85};
		send_key(key);
		key = {TAG_SEQUENCE, 8'h04, TAG_INTEGER, ZERO_BYTE, TAG_INTEGER, LEN_LONG_FORM, 8'hFF};
		send_key(key);
		// modulus of 513 bytes without leading zero, then a key that ends right after its modulus
		key = {TAG_SEQUENCE, 8'h10, TAG_INTEGER, 8'h82, 8'h02, 8'h01, 8'h01};
		send_key(key);
		key = {TAG_SEQUENCE, 8'h03, TAG_INTEGER, 8'h01, 8'hFF};
		send_key(key);

		while (useful_beats < 750) begin
			case ((keys_sent / 3) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 56;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 56;
			end
			default: begin
				send_idle_pct = 10;
				recv_stall_pct = 10;
			end
			endcase
			pick = $urandom_range(99);
			key.delete();
			ints.delete();
			alg.delete();
			bits.delete();
			outer.delete();
			if (pick >= 93) begin
				repeat ($urandom_range(6, 1)) key.push_back(8'($urandom_range(255)));
			end else if (pick >= 88) begin
				if ($urandom_range(1)) put_integer(ints, $urandom_range(3, 1));
				big_len = $urandom_range(1) ? $urandom_range(520, 513) : $urandom;
				ints.push_back(TAG_INTEGER);
				put_len(ints, big_len);
				ints.push_back($urandom_range(1) ? ZERO_BYTE : 8'($urandom_range(255, 1)));
				repeat ($urandom_range(2)) ints.push_back(8'($urandom_range(255)));
				wrap(key, TAG_SEQUENCE, ints);
				useful_beats += key.size();
			end else begin
				put_integer(ints, ($urandom_range(24) == 0) ? $urandom_range(300, 128)
					: $urandom_range(24));
				put_integer(ints, $urandom_range(4));
				if ($urandom_range(1)) begin
					repeat ($urandom_range(13)) alg.push_back(8'($urandom_range(255)));
					wrap(outer, TAG_SEQUENCE, alg);
					wrap(bits, TAG_SEQUENCE, ints);
					bits.push_front(($urandom_range(3) == 0) ? 8'($urandom_range(255))
						: ZERO_BYTE);
					wrap(outer, TAG_BIT_STRING, bits);
					wrap(key, TAG_SEQUENCE, outer);
				end else begin
					wrap(key, TAG_SEQUENCE, ints);
				end
				useful_beats += key.size();
				if (pick >= 80)
					key[$urandom_range(key.size() - 1)] = 8'($urandom_range(255));
				else if (pick >= 70)
					key = key[0 : $urandom_range(key.size() - 2)];
				else if ($urandom_range(4) == 0)
					repeat ($urandom_range(3, 1)) key.push_back(8'($urandom_range(255)));
			end
			send_key(key);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("Covered %0d keys in %0d byte beats over four handshake mixes;",
			keys_sent, beats_sent);
		$display("%0d beats checked, %0d mismatches; done beats ok %0d, bad tag %0d,",
			sb.checked, sb.mismatches, sb.done_count[ST_OK], sb.done_count[ST_TAG]);
		$display("length form %0d, truncated %0d, too large %0d",
			sb.done_count[ST_FORM], sb.done_count[ST_TRUNC], sb.done_count[ST_BIG]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d beats outstanding", sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
